>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the event scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define KES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

>>> sv/kes_pkg.sv
// Types and constants shared by the key and encoder event scanner.
`default_nettype none
package kes_pkg;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_UP          = 4'd1,
    EV_DOWN        = 4'd2,
    EV_LEFT        = 4'd3,
    EV_RIGHT       = 4'd4,
    EV_RUN         = 4'd5,
    EV_SELECT      = 4'd6,
    EV_MODE        = 4'd7,
    EV_DOUBLE_MODE = 4'd8,
    EV_SELECT_HOLD = 4'd9,
    EV_RUN_HOLD    = 4'd10,
    EV_MODE_HOLD   = 4'd11
  } event_t;

  typedef enum logic [2:0] {
    REG_DOUBLE_CLICK = 3'd0,
    REG_HOLD_DELAY   = 3'd1,
    REG_FIRST_REPEAT = 3'd2,
    REG_HOLD_REPEAT  = 3'd3,
    REG_MODE_LOCK    = 3'd4,
    REG_SELECT_LOCK  = 3'd5
  } reg_index_t;

  localparam int unsigned KEY_MODE_BIT   = 0;
  localparam int unsigned KEY_RUN_BIT    = 1;
  localparam int unsigned KEY_SELECT_BIT = 7;
  localparam logic [7:0]  KEY_HOLDABLE   = 8'h83;

  localparam logic [15:0] CLICK_MS_MAX = 16'hFFFF;

  localparam logic [15:0] RST_DOUBLE_CLICK = 16'd300;
  localparam logic [7:0]  RST_HOLD_DELAY   = 8'd30;
  localparam logic [7:0]  RST_FIRST_REPEAT = 8'd3;
  localparam logic [7:0]  RST_HOLD_REPEAT  = 8'd150;
  localparam logic [9:0]  RST_MODE_LOCK    = 10'd200;
  localparam logic [9:0]  RST_SELECT_LOCK  = 10'd100;

  typedef struct packed {
    logic [15:0] double_click_ms;
    logic [7:0]  hold_delay_scans;
    logic [7:0]  first_repeat_scans;
    logic [7:0]  hold_repeat_scans;
    logic [9:0]  mode_lock_ms;
    logic [9:0]  select_lock_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  last_keys;
    logic [7:0]  hold_wait;
    logic [7:0]  repeat_wait;
    logic        click_pending;
    logic [15:0] click_ms;
    logic        pending_run;
    logic        pending_select;
    logic        pending_mode;
  } scan_state_t;

endpackage
`default_nettype wire

>>> sv/key_and_encoder_event_scanner_unit.sv
// Top level of the key and encoder event scanner with its register port.
//
// Each input transaction is one 1 ms tick carrying the key levels (bit 0
// mode, bit 1 run, bit 7 select, 1 = pressed) and four active-low encoder
// contacts. Every accepted tick yields exactly one output transaction with
// an event code; the code is zero on every tick that is not a scan tick.
// Scan ticks come once every SCAN_PERIOD ticks, starting with the first tick
// after reset. Encoder contacts are sampled on odd tick phases and the
// resulting event is reported on the next scan unless a new key press or a key event displaces it.
// The code of a tick appears on out_key_event in the cycle after the tick
// is accepted. Throughput is one tick per cycle while the receiver is
// ready, set by the single output register; all state updates for a tick
// are done in the cycle it is accepted.
// When the receiver stalls, the output register holds its transaction and
// in_ready drops, so no tick is taken until the held result is accepted.
// Reset is synchronous and active low. It clears all scanner state and the
// output valid flag and loads the timing registers with their defaults.
// Timing registers are written over the APB port at byte address 4*index and
// should only be written while no tick is in flight.
`default_nettype none
`include "assert_macros.svh"
module key_and_encoder_event_scanner_unit #(
  parameter int unsigned SCAN_PERIOD = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Tick input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_key_bits,
  input  wire logic        in_pin_up,
  input  wire logic        in_pin_down,
  input  wire logic        in_pin_left,
  input  wire logic        in_pin_right,
  // Event output channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_key_event,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned PHASE_W = $clog2(SCAN_PERIOD);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SCAN_PERIOD - 1);

  // Timing registers.
  kes_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  kes_pkg::reg_index_t cfg_idx;

  // Scanner state.
  logic [PHASE_W-1:0]   scan_phase_r, scan_phase_nxt;
  kes_pkg::scan_state_t scan_r, scan_nxt, scan_cur;
  logic [1:0]           vert_last_r, vert_last_nxt;
  logic [1:0]           horiz_last_r, horiz_last_nxt;
  kes_pkg::event_t      enc_event_r, enc_event_nxt, enc_sampled;
  logic [9:0]           vert_lock_r, vert_lock_nxt, vert_lock_dec;
  logic [9:0]           horiz_lock_r, horiz_lock_nxt, horiz_lock_dec;

  // Output register.
  logic            out_valid_r;
  kes_pkg::event_t out_key_event_r, code_nxt;

  // Scan block results.
  kes_pkg::scan_state_t scan_res;
  kes_pkg::event_t      scan_code;

  logic in_accept;
  logic scan_due;
  logic odd_phase;
  logic up_on, down_on, left_on, right_on;

  // ---------------------------------------------------------------------
  // Register port. Writes complete in the access phase; reads are
  // combinational since pready never stalls.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = kes_pkg::reg_index_t'(paddr[4:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      kes_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, cfg_r.double_click_ms};
      kes_pkg::REG_HOLD_DELAY:   prdata = {24'd0, cfg_r.hold_delay_scans};
      kes_pkg::REG_FIRST_REPEAT: prdata = {24'd0, cfg_r.first_repeat_scans};
      kes_pkg::REG_HOLD_REPEAT:  prdata = {24'd0, cfg_r.hold_repeat_scans};
      kes_pkg::REG_MODE_LOCK:    prdata = {22'd0, cfg_r.mode_lock_ms};
      kes_pkg::REG_SELECT_LOCK:  prdata = {22'd0, cfg_r.select_lock_ms};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_click_ms    <= kes_pkg::RST_DOUBLE_CLICK;
      cfg_r.hold_delay_scans   <= kes_pkg::RST_HOLD_DELAY;
      cfg_r.first_repeat_scans <= kes_pkg::RST_FIRST_REPEAT;
      cfg_r.hold_repeat_scans  <= kes_pkg::RST_HOLD_REPEAT;
      cfg_r.mode_lock_ms       <= kes_pkg::RST_MODE_LOCK;
      cfg_r.select_lock_ms     <= kes_pkg::RST_SELECT_LOCK;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        kes_pkg::REG_DOUBLE_CLICK: cfg_r.double_click_ms    <= pwdata[15:0];
        kes_pkg::REG_HOLD_DELAY:   cfg_r.hold_delay_scans   <= pwdata[7:0];
        kes_pkg::REG_FIRST_REPEAT: cfg_r.first_repeat_scans <= pwdata[7:0];
        kes_pkg::REG_HOLD_REPEAT:  cfg_r.hold_repeat_scans  <= pwdata[7:0];
        kes_pkg::REG_MODE_LOCK:    cfg_r.mode_lock_ms       <= pwdata[9:0];
        kes_pkg::REG_SELECT_LOCK:  cfg_r.select_lock_ms     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. A new tick is taken whenever the output register is empty
  // or its transaction leaves in this same cycle.
  // ---------------------------------------------------------------------
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_key_event = out_key_event_r;

  // ---------------------------------------------------------------------
  // Per-tick update. Timers advance first, then the encoders are sampled,
  // then the key scan runs on phase zero.
  // ---------------------------------------------------------------------
  assign up_on    = ~in_pin_up;
  assign down_on  = ~in_pin_down;
  assign left_on  = ~in_pin_left;
  assign right_on = ~in_pin_right;

  assign scan_due  = (scan_phase_r == '0);
  assign odd_phase = scan_phase_r[0];

  assign vert_lock_dec  = (vert_lock_r  != '0) ? vert_lock_r  - 10'd1 : vert_lock_r;
  assign horiz_lock_dec = (horiz_lock_r != '0) ? horiz_lock_r - 10'd1 : horiz_lock_r;

  // Timers that run before the scan: the click timer saturates, and the
  // hold and repeat counters only count on scan ticks.
  always_comb begin
    scan_cur = scan_r;
    if (scan_r.click_pending && (scan_r.click_ms != kes_pkg::CLICK_MS_MAX)) begin
      scan_cur.click_ms = scan_r.click_ms + 16'd1;
    end
    if (scan_due) begin
      if (scan_r.hold_wait != '0) begin
        scan_cur.hold_wait = scan_r.hold_wait - 8'd1;
      end
      if (scan_r.repeat_wait != '0) begin
        scan_cur.repeat_wait = scan_r.repeat_wait - 8'd1;
      end
    end
  end

  // Encoder sampling. The contact state is only tracked while its lockout
  // is idle; a horizontal event in the same tick replaces a vertical one.
  always_comb begin
    enc_sampled    = enc_event_r;
    vert_last_nxt  = vert_last_r;
    horiz_last_nxt = horiz_last_r;
    if (odd_phase) begin
      if (vert_lock_dec == '0) begin
        if (up_on && !vert_last_r[0]) begin
          enc_sampled = down_on ? kes_pkg::EV_UP : kes_pkg::EV_DOWN;
        end
        vert_last_nxt = {down_on, up_on};
      end
      if (horiz_lock_dec == '0) begin
        if (left_on && !horiz_last_r[0]) begin
          enc_sampled = right_on ? kes_pkg::EV_LEFT : kes_pkg::EV_RIGHT;
        end
        horiz_last_nxt = {right_on, left_on};
      end
    end
  end

  kes_scan u_scan (
    .keys      (in_key_bits),
    .cur       (scan_cur),
    .enc_event (enc_sampled),
    .cfg       (cfg_r),
    .nxt       (scan_res),
    .code      (scan_code)
  );

  // Scan results, lockout loads and the phase counter.
  always_comb begin
    scan_nxt       = scan_cur;
    enc_event_nxt  = enc_sampled;
    vert_lock_nxt  = vert_lock_dec;
    horiz_lock_nxt = horiz_lock_dec;
    code_nxt       = kes_pkg::EV_NONE;
    if (scan_due) begin
      scan_nxt      = scan_res;
      enc_event_nxt = kes_pkg::EV_NONE;
      code_nxt      = scan_code;
      if (scan_code == kes_pkg::EV_MODE) begin
        vert_lock_nxt = cfg_r.mode_lock_ms;
      end
      if (scan_code == kes_pkg::EV_SELECT) begin
        horiz_lock_nxt = cfg_r.select_lock_ms;
      end
    end
    scan_phase_nxt = (scan_phase_r == PHASE_LAST) ? '0 : scan_phase_r + PHASE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_phase_r <= '0;
      scan_r       <= '0;
      vert_last_r  <= '0;
      horiz_last_r <= '0;
      enc_event_r  <= kes_pkg::EV_NONE;
      vert_lock_r  <= '0;
      horiz_lock_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        scan_phase_r <= scan_phase_nxt;
        scan_r       <= scan_nxt;
        vert_last_r  <= vert_last_nxt;
        horiz_last_r <= horiz_last_nxt;
        enc_event_r  <= enc_event_nxt;
        vert_lock_r  <= vert_lock_nxt;
        horiz_lock_r <= horiz_lock_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_key_event_r <= code_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  `KES_ASSERT_NEXT(a_quiet_off_scan, clk, rst_n, in_accept && !scan_due, out_valid && out_key_event == kes_pkg::EV_NONE)
  `KES_ASSERT_IMPL(a_phase_in_range, clk, rst_n, 1'b1, scan_phase_r <= PHASE_LAST)
  `KES_ASSERT_IMPL(a_click_idle_zero, clk, rst_n, !scan_r.click_pending, scan_r.click_ms == '0)
  `KES_ASSERT_NEXT(a_scan_clears_enc, clk, rst_n, in_accept && scan_due, enc_event_r == kes_pkg::EV_NONE)

endmodule
`default_nettype wire

>>> sv/kes_scan.sv
// Key scan logic: press, release, click and hold decisions for one scan tick.
`default_nettype none
module kes_scan (
  input  wire logic [7:0]          keys,
  input  wire kes_pkg::scan_state_t cur,
  input  wire kes_pkg::event_t     enc_event,
  input  wire kes_pkg::cfg_t       cfg,
  output kes_pkg::scan_state_t     nxt,
  output kes_pkg::event_t          code
);

  logic new_press;
  logic any_held;

  assign new_press = |(keys & ~cur.last_keys);
  assign any_held  = |(keys & cur.last_keys);

  always_comb begin
    nxt  = cur;
    code = kes_pkg::EV_NONE;
    if (new_press) begin
      nxt.hold_wait   = cfg.hold_delay_scans;
      nxt.repeat_wait = cfg.first_repeat_scans;
      if (keys[kes_pkg::KEY_RUN_BIT]) begin
        nxt.pending_run = 1'b1;
      end
      if (keys[kes_pkg::KEY_SELECT_BIT]) begin
        nxt.pending_select = 1'b1;
      end
      if (keys[kes_pkg::KEY_MODE_BIT]) begin
        nxt.click_ms = '0;
        if (cur.click_pending) begin
          nxt.click_pending = 1'b0;
          code = (cur.click_ms < cfg.double_click_ms) ? kes_pkg::EV_DOUBLE_MODE
                                                      : kes_pkg::EV_MODE;
        end else begin
          nxt.click_pending = 1'b1;
          nxt.pending_mode  = 1'b1;
        end
      end
    end else begin
      code = enc_event;
      if (any_held) begin
        // Hold fires once both the first delay and the repeat gap have run out.
        if (cur.hold_wait == '0 && cur.repeat_wait == '0) begin
          if (keys[kes_pkg::KEY_SELECT_BIT]) begin
            code = kes_pkg::EV_SELECT_HOLD;
            nxt.pending_select = 1'b0;
          end
          if (keys[kes_pkg::KEY_RUN_BIT]) begin
            code = kes_pkg::EV_RUN_HOLD;
            nxt.pending_run = 1'b0;
          end
          if (keys[kes_pkg::KEY_MODE_BIT]) begin
            code = kes_pkg::EV_MODE_HOLD;
            nxt.pending_mode  = 1'b0;
            nxt.click_pending = 1'b0;
            nxt.click_ms      = '0;
          end
          if (|(keys & kes_pkg::KEY_HOLDABLE)) begin
            nxt.repeat_wait = cfg.hold_repeat_scans;
          end
        end
      end else begin
        if (cur.pending_select) begin
          code = kes_pkg::EV_SELECT;
          nxt.pending_select = 1'b0;
        end
        if (cur.pending_run) begin
          code = kes_pkg::EV_RUN;
          nxt.pending_run = 1'b0;
        end
        // A single mode click resolves once the double-click window has passed.
        if (cur.pending_mode && cur.click_pending &&
            (cur.click_ms > cfg.double_click_ms)) begin
          code = kes_pkg::EV_MODE;
          nxt.pending_mode  = 1'b0;
          nxt.click_pending = 1'b0;
          nxt.click_ms      = '0;
        end
        nxt.hold_wait = cfg.hold_delay_scans;
      end
    end
    nxt.last_keys = keys;
  end

endmodule
`default_nettype wire
